@@ rtl/core/autocorrelation_with_tau_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the autocorrelation core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AUTOCORRELATION_WITH_TAU_CORE_DEFINES_SVH
`define AUTOCORRELATION_WITH_TAU_CORE_DEFINES_SVH

// Same-cycle implication.
`define ACWT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ACWT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/acwt_pkg.sv @@
// ----------------------------------------------------------------------------
// acwt_pkg
// Types and constants shared by the autocorrelation core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none
package acwt_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int NUM_LAGS_DEF    = 32;

  localparam logic [63:0] TAU_START = 64'd32768;

  localparam logic KIND_CORR = 1'b0;
  localparam logic KIND_TAU  = 1'b1;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } acwt_in_t;

  typedef struct packed {
    logic [5:0]         lag;
    logic               kind;
    logic signed [23:0] value;
    logic               final_res;
  } acwt_out_t;

  // Control broadcast to every cell of the lag chain.
  typedef struct packed {
    logic clear;
    logic shift;
    logic feed;
  } acwt_cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/acwt_ram.sv @@
// ----------------------------------------------------------------------------
// acwt_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module acwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/acwt_div.sv @@
// ----------------------------------------------------------------------------
// acwt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module acwt_div #(
  parameter int NW = 80,
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW:0]      rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DW:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem[DW-1:0], quo[NW-1]};
  assign fits   = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !run) begin
        run <= 1'b1;
        cnt <= CNT_W'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !run) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (run) begin
      rem <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/acwt_cell.sv @@
// ----------------------------------------------------------------------------
// acwt_cell
// One lag of the correlation chain: delay tap, Q16 product and sums.
// ----------------------------------------------------------------------------
`default_nettype none
module acwt_cell import acwt_pkg::*; #(
  parameter int SUM_W = 45
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire acwt_cell_ctl_t          ctl,
  input  wire logic signed [32:0]      b,
  input  wire logic signed [32:0]      a_in,
  input  wire logic                    a_vld_in,
  output logic signed      [32:0]      a_out,
  output logic                         a_vld_out,
  input  wire logic signed [63:0]      c_in,
  input  wire logic signed [SUM_W-1:0] s1_in,
  input  wire logic signed [SUM_W-1:0] s2_in,
  output logic signed      [63:0]      c_out,
  output logic signed      [SUM_W-1:0] s1_out,
  output logic signed      [SUM_W-1:0] s2_out
);

  logic signed [65:0] prod;
  logic signed [65:0] prod_sh;
  logic signed [49:0] pq;
  logic               en;
  logic signed [32:0] a_d;
  logic signed [32:0] b_d;
  logic signed [64:0] sum65;

  assign prod    = a_in * b;
  assign prod_sh = prod >>> 16;
  assign sum65   = {c_out[63], c_out} + {{15{pq[49]}}, pq};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld_out <= 1'b0;
      en        <= 1'b0;
    end else begin
      a_vld_out <= a_vld_in && !ctl.clear;
      en        <= ctl.feed && a_vld_in && !ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    a_out <= a_in;
    pq    <= prod_sh[49:0];
    a_d   <= a_in;
    b_d   <= b;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      c_out  <= '0;
      s1_out <= '0;
      s2_out <= '0;
    end else if (ctl.shift) begin
      c_out  <= c_in;
      s1_out <= s1_in;
      s2_out <= s2_in;
    end else if (en) begin
      // The product sum saturates at the signed 64-bit limits.
      if (sum65[64] != sum65[63]) begin
        c_out <= sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        c_out <= sum65[63:0];
      end
      s1_out <= s1_out + {{(SUM_W-33){a_d[32]}}, a_d};
      s2_out <= s2_out + {{(SUM_W-33){b_d[32]}}, b_d};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/autocorrelation_with_tau_core.sv @@
// ----------------------------------------------------------------------------
// autocorrelation_with_tau_core
// Windowed autocorrelation per lag and integrated autocorrelation time.
// ----------------------------------------------------------------------------
// Usage: samples arrive one beat at a time on item, accepted when start is
// high and busy is low, one per cycle while loading. Samples past the store
// capacity are dropped. A beat with item.last set stores its sample and
// starts the final pass; busy stays high until the pass is over.
// The pass streams the series twice through a chain of NUM_LAGS cells, one
// sample per cycle. Per lag, three divisions by the window length and one
// ratio run on a shared divider; the global mean takes one more division
// and every lag of the tau window after lag 0 one ratio. Results leave on
// result with strobe high for exactly one cycle: NUM_LAGS correlations in
// lag order, then tau with final_res set. The receiver cannot stall the
// core. Reset clears the sample count and the lag sums; the sample store
// contents are don't-care until written.
// ----------------------------------------------------------------------------
`default_nettype none
module autocorrelation_with_tau_core import acwt_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int NUM_LAGS    = NUM_LAGS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire acwt_in_t  item,
  output logic           busy,
  output logic           strobe,
  output acwt_out_t      result
);

  `include "autocorrelation_with_tau_core_defines.svh"

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = 33 + AW;

  typedef enum logic [17:0] {
    ST_IDLE      = 18'h00001,
    ST_FEED      = 18'h00002,
    ST_DRAIN     = 18'h00004,
    ST_LAG_START = 18'h00008,
    ST_DIV_C     = 18'h00010,
    ST_DIV_S1    = 18'h00020,
    ST_DIV_S2    = 18'h00040,
    ST_MUL       = 18'h00080,
    ST_COV       = 18'h00100,
    ST_RATIO_CHK = 18'h00200,
    ST_RATIO     = 18'h00400,
    ST_EMIT_W    = 18'h00800,
    ST_GMEAN     = 18'h01000,
    ST_G_START   = 18'h02000,
    ST_G_RATIO   = 18'h04000,
    ST_G_CHECK   = 18'h08000,
    ST_G_NEXT    = 18'h10000,
    ST_EMIT_T    = 18'h20000
  } acwt_state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  acwt_state_t state;
  logic [CW-1:0]  count;
  logic [CW-1:0]  rd_cnt;
  logic           rd_vld;
  logic [2:0]     drain;
  logic           pass2;
  logic [5:0]     lag;
  logic           div_wait;

  logic signed [63:0] total;
  logic signed [31:0] gmean;
  logic signed [63:0] mc;
  logic signed [32:0] a1;
  logic signed [32:0] a2;
  logic signed [63:0] prod;
  logic signed [63:0] cov;
  logic signed [63:0] cov0;
  logic signed [63:0] wval;
  logic signed [63:0] norm;
  logic signed [63:0] tau;

  // RAM
  logic        accept;
  logic        ram_we;
  logic [31:0] rdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (count < CW'(MAX_SAMPLES));

  acwt_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (item.sample),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (rdata)
  );

  // Cell chain
  acwt_cell_ctl_t     ctl;
  logic signed [32:0] b_feed;
  logic signed [32:0] x33;

  logic signed [32:0]      a_chain  [NUM_LAGS+1];
  logic                    av_chain [NUM_LAGS+1];
  logic signed [63:0]      c_chain  [NUM_LAGS+1];
  logic signed [SUM_W-1:0] s1_chain [NUM_LAGS+1];
  logic signed [SUM_W-1:0] s2_chain [NUM_LAGS+1];

  assign ctl.clear = (state == ST_IDLE) || (state == ST_GMEAN);
  assign ctl.shift = (state == ST_EMIT_W) || (state == ST_G_NEXT);
  assign ctl.feed  = rd_vld;

  assign x33    = {rdata[31], rdata};
  assign b_feed = pass2 ? (x33 - {gmean[31], gmean}) : x33;

  assign a_chain[0]  = b_feed;
  assign av_chain[0] = rd_vld;

  // Chain outputs are indexed by cell; entry NUM_LAGS feeds zeros on shift.
  logic signed [63:0]      c_sh  [NUM_LAGS+1];
  logic signed [SUM_W-1:0] s1_sh [NUM_LAGS+1];
  logic signed [SUM_W-1:0] s2_sh [NUM_LAGS+1];

  assign c_sh[NUM_LAGS]  = '0;
  assign s1_sh[NUM_LAGS] = '0;
  assign s2_sh[NUM_LAGS] = '0;

  for (genvar k = 0; k < NUM_LAGS; k++) begin : g_cell
    acwt_cell #(.SUM_W(SUM_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .b         (b_feed),
      .a_in      (a_chain[k]),
      .a_vld_in  (av_chain[k]),
      .a_out     (a_chain[k+1]),
      .a_vld_out (av_chain[k+1]),
      .c_in      (c_sh[k+1]),
      .s1_in     (s1_sh[k+1]),
      .s2_in     (s2_sh[k+1]),
      .c_out     (c_chain[k]),
      .s1_out    (s1_chain[k]),
      .s2_out    (s2_chain[k])
    );
    assign c_sh[k]  = c_chain[k];
    assign s1_sh[k] = s1_chain[k];
    assign s2_sh[k] = s2_chain[k];
  end

  assign c_chain[NUM_LAGS]  = c_sh[NUM_LAGS];
  assign s1_chain[NUM_LAGS] = s1_sh[NUM_LAGS];
  assign s2_chain[NUM_LAGS] = s2_sh[NUM_LAGS];

  // The sequencer always works on the head cell.
  logic signed [63:0] c0;
  logic signed [63:0] s10;
  logic signed [63:0] s20;
  logic [CW-1:0]      m;

  assign c0  = c_chain[0];
  assign s10 = {{(64-SUM_W){s1_chain[0][SUM_W-1]}}, s1_chain[0]};
  assign s20 = {{(64-SUM_W){s2_chain[0][SUM_W-1]}}, s2_chain[0]};
  assign m   = count - CW'(lag);

  // Shared divider
  logic        div_start;
  logic [79:0] div_num;
  logic [63:0] div_den;
  logic        div_done;
  logic [79:0] div_q;
  logic        div_neg;

  always_comb begin
    div_num = '0;
    div_den = 64'd1;
    div_neg = 1'b0;
    case (state)
      ST_DIV_C: begin
        div_num = {16'd0, mag64(c0)};
        div_den = 64'(m);
        div_neg = c0[63];
      end
      ST_DIV_S1: begin
        div_num = {16'd0, mag64(s10)};
        div_den = 64'(m);
        div_neg = s10[63];
      end
      ST_DIV_S2: begin
        div_num = {16'd0, mag64(s20)};
        div_den = 64'(m);
        div_neg = s20[63];
      end
      ST_GMEAN: begin
        div_num = {16'd0, mag64(total)};
        div_den = 64'(count);
        div_neg = total[63];
      end
      ST_RATIO: begin
        div_num = {mag64(cov), 16'd0};
        div_den = mag64(cov0);
        div_neg = cov[63] ^ cov0[63];
      end
      ST_G_RATIO: begin
        div_num = {mag64(c0), 16'd0};
        div_den = mag64(norm);
        div_neg = c0[63] ^ norm[63];
      end
      default: begin
        div_num = '0;
        div_den = 64'd1;
        div_neg = 1'b0;
      end
    endcase
  end

  assign div_start = !div_wait;

  acwt_div #(.NW(80), .DW(64)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start && (state == ST_DIV_C || state == ST_DIV_S1 ||
                          state == ST_DIV_S2 || state == ST_GMEAN ||
                          state == ST_RATIO || state == ST_G_RATIO)),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  logic signed [63:0] q_plain;
  logic [63:0]        q_ratio_mag;
  logic signed [63:0] q_ratio;

  // The integer part of a ratio is clamped to 2^40.
  assign q_ratio_mag = (div_q[79:16] > 64'h100_0000_0000) ?
                       {48'h0100_0000_0000, div_q[15:0]} : div_q[63:0];
  assign q_plain     = div_neg ? -div_q[63:0] : div_q[63:0];
  assign q_ratio     = div_neg ? -q_ratio_mag : q_ratio_mag;

  logic signed [65:0] mprod;
  logic signed [65:0] mprod_sh;
  logic signed [63:0] cov_new;
  logic signed [63:0] tau_new;
  logic signed [66:0] tau6;
  logic signed [66:0] lag_q16;

  assign mprod    = a1 * a2;
  assign mprod_sh = mprod >>> 16;
  assign cov_new  = mc - prod;
  assign tau_new  = tau + q_ratio;
  assign tau6     = ({{3{tau[63]}}, tau} <<< 2) + ({{3{tau[63]}}, tau} <<< 1);
  assign lag_q16  = {45'd0, lag, 16'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_cnt   <= '0;
      rd_vld   <= 1'b0;
      drain    <= '0;
      pass2    <= 1'b0;
      lag      <= '0;
      div_wait <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      rd_vld <= (state == ST_FEED) && (rd_cnt < count);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (ram_we) begin
              count <= count + 1'b1;
            end
            if (item.last) begin
              state  <= ST_FEED;
              rd_cnt <= '0;
              pass2  <= 1'b0;
            end
          end
        end
        ST_FEED: begin
          if (rd_cnt < count) begin
            rd_cnt <= rd_cnt + 1'b1;
          end else begin
            state <= ST_DRAIN;
            drain <= '0;
          end
        end
        ST_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == 3'd4) begin
            lag   <= '0;
            state <= pass2 ? ST_G_START : ST_LAG_START;
          end
        end
        ST_LAG_START: begin
          if (lag == 6'd0) begin
            total <= s10;
          end
          if (CW'(lag) >= count) begin
            wval  <= '0;
            state <= ST_EMIT_W;
          end else begin
            state <= ST_DIV_C;
          end
        end
        ST_DIV_C, ST_DIV_S1, ST_DIV_S2, ST_RATIO, ST_GMEAN, ST_G_RATIO: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
          end else if (div_done) begin
            div_wait <= 1'b0;
            case (state)
              ST_DIV_C: begin
                mc    <= q_plain;
                state <= ST_DIV_S1;
              end
              ST_DIV_S1: begin
                a1    <= q_plain[32:0];
                state <= ST_DIV_S2;
              end
              ST_DIV_S2: begin
                a2    <= q_plain[32:0];
                state <= ST_MUL;
              end
              ST_RATIO: begin
                wval  <= q_ratio;
                state <= ST_EMIT_W;
              end
              ST_GMEAN: begin
                gmean  <= q_plain[31:0];
                tau    <= TAU_START;
                pass2  <= 1'b1;
                rd_cnt <= '0;
                state  <= ST_FEED;
              end
              ST_G_RATIO: begin
                tau   <= tau_new;
                state <= ST_G_CHECK;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MUL: begin
          prod  <= mprod_sh[63:0];
          state <= ST_COV;
        end
        ST_COV: begin
          cov <= cov_new;
          if (lag == 6'd0) begin
            cov0 <= cov_new;
          end
          state <= ST_RATIO_CHK;
        end
        ST_RATIO_CHK: begin
          if (cov0 == '0) begin
            wval  <= '0;
            state <= ST_EMIT_W;
          end else begin
            state <= ST_RATIO;
          end
        end
        ST_EMIT_W: begin
          strobe           <= 1'b1;
          result.lag       <= lag;
          result.kind      <= KIND_CORR;
          result.value     <= sat24(wval);
          result.final_res <= 1'b0;
          lag              <= lag + 1'b1;
          state <= (lag == 6'(NUM_LAGS - 1)) ? ST_GMEAN : ST_LAG_START;
        end
        ST_G_START: begin
          if (lag == 6'd0) begin
            norm  <= c0;
            // A zero or negative lag-0 sum ends the window at once.
            state <= (c0 <= 0) ? ST_EMIT_T : ST_G_NEXT;
          end else begin
            state <= ST_G_RATIO;
          end
        end
        ST_G_CHECK: begin
          if (tau6 < lag_q16 || c0 <= 0) begin
            state <= ST_EMIT_T;
          end else begin
            state <= ST_G_NEXT;
          end
        end
        ST_G_NEXT: begin
          lag   <= lag + 1'b1;
          state <= (lag == 6'(NUM_LAGS - 1)) ? ST_EMIT_T : ST_G_START;
        end
        ST_EMIT_T: begin
          strobe           <= 1'b1;
          result.lag       <= '0;
          result.kind      <= KIND_TAU;
          result.value     <= sat24(tau);
          result.final_res <= 1'b1;
          count            <= '0;
          state            <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ACWT_ASSERT_IMP(a_tau_clears_count, strobe && result.final_res, count == '0, "count not cleared")
  `ACWT_ASSERT_IMP(a_corr_kind, strobe && !result.final_res, result.kind == KIND_CORR, "non-final result is not a correlation")
  `ACWT_ASSERT_IMP(a_feed_bound, state == ST_FEED, rd_cnt <= count, "read pointer ran past the series")
  `ACWT_ASSERT_NXT(a_last_starts_pass, accept && item.last, busy, "last beat did not start the pass")

endmodule
`default_nettype wire
